// ----- sv/rvb_pkg.sv -----
// Package for the radial vignette brightness block: widths, codes and shared types.
`default_nettype none
package rvb_pkg;

  // Geometry and fixed-point setup
  localparam int MAX_DIM          = 4096;
  localparam int FACTOR_FRAC_BITS = 12;

  // Fixed field widths
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_FAC_W  = 16;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int D_W     = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 2;
  localparam int D2_W    = 2 * D_W - 1;
  localparam int R_W     = DIM_W + CFG_FAC_W;
  localparam int ROOT_W  = D_W + FACTOR_FRAC_BITS;
  localparam int CMP_W   = (ROOT_W > R_W) ? ROOT_W : R_W;
  localparam int DIST_SH = FACTOR_FRAC_BITS - 7;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = FRAC_W + 1;

  // Request to result, in clock edges
  localparam int LATENCY = 5 + ROOT_W + Q_W;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_START_FACTOR      = 3'd2,
    REG_END_FACTOR        = 3'd3,
    REG_PIXEL_FORMAT      = 3'd4,
    REG_BRIGHTNESS_ENABLE = 3'd5
  } cfg_reg_e;

  // Per-pixel treatment chosen before the divider
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ZERO,
    MODE_SCALE
  } mode_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    logic [CFG_FAC_W-1:0] start_f;
    logic [CFG_FAC_W-1:0] end_f;
    logic                 colour;
    logic                 enable;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] c;
  } chans_t;

  // Carried alongside the square root
  typedef struct packed {
    logic [R_W-1:0] rs;
    logic [R_W-1:0] re;
    chans_t         ch;
    logic           colour;
    logic           enable;
  } side_t;

  // Queue entry between front and back
  typedef struct packed {
    logic [D2_W-1:0] d2;
    side_t           side;
  } geom_t;

  // Carried alongside the divider
  typedef struct packed {
    mode_e  mode;
    logic   colour;
    chans_t ch;
  } scl_t;

endpackage
`default_nettype wire

// ----- sv/rvb_front.sv -----
// Front end: centre offsets, radii and squared distance for each pixel request.
`default_nettype none
module rvb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [rvb_pkg::COORD_W-1:0] column_i,
  input  logic [rvb_pkg::COORD_W-1:0] row_i,
  input  rvb_pkg::chans_t            ch_i,
  input  rvb_pkg::cfg_t              cfg_i,
  output logic                       valid_o,
  output rvb_pkg::geom_t             item_o
);

  localparam int DW = rvb_pkg::D_W;
  localparam int RW = rvb_pkg::R_W;

  int                              wcl, hcl;
  logic [rvb_pkg::DIM_W-1:0]       w1, h1;
  logic [rvb_pkg::CFG_FAC_W-1:0]   ef;
  logic signed [DW-1:0]            dx_d, dy_d;
  logic signed [DW-1:0]            dx_q, dy_q;
  logic [RW-1:0]                   rs_d, re_d;
  rvb_pkg::side_t                  side_q, side2_q;
  logic                            v1_q, v2_q;
  logic [2*DW-1:0]                 sqx, sqy;
  logic [rvb_pkg::D2_W-1:0]        d2_d, d2_q;

  // Stage 1: clamp dimensions, offsets in half pixels, radii
  always_comb begin
    wcl = (cfg_i.width == '0) ? 1 :
          ((int'(cfg_i.width) > rvb_pkg::MAX_DIM) ? rvb_pkg::MAX_DIM : int'(cfg_i.width));
    hcl = (cfg_i.height == '0) ? 1 :
          ((int'(cfg_i.height) > rvb_pkg::MAX_DIM) ? rvb_pkg::MAX_DIM : int'(cfg_i.height));
    w1 = rvb_pkg::DIM_W'(wcl - 1);
    h1 = rvb_pkg::DIM_W'(hcl - 1);
    ef = (cfg_i.end_f < cfg_i.start_f) ? cfg_i.start_f : cfg_i.end_f;
    dx_d = DW'({column_i, 1'b0}) - DW'(w1);
    dy_d = DW'({row_i, 1'b0}) - DW'(h1);
    rs_d = RW'(w1) * RW'(cfg_i.start_f);
    re_d = RW'(w1) * RW'(ef);
  end

  always_ff @(posedge clk_i) begin
    dx_q          <= dx_d;
    dy_q          <= dy_d;
    side_q.rs     <= rs_d;
    side_q.re     <= re_d;
    side_q.ch     <= ch_i;
    side_q.colour <= cfg_i.colour;
    side_q.enable <= cfg_i.enable;
  end

  // Stage 2: squared distance, full-width signed products
  always_comb begin
    sqx  = (2*DW)'(dx_q * dx_q);
    sqy  = (2*DW)'(dy_q * dy_q);
    d2_d = rvb_pkg::D2_W'(sqx) + rvb_pkg::D2_W'(sqy);
  end

  always_ff @(posedge clk_i) begin
    d2_q    <= d2_d;
    side2_q <= side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o     = v2_q;
  assign item_o.d2   = d2_q;
  assign item_o.side = side2_q;

endmodule
`default_nettype wire

// ----- sv/rvb_queue.sv -----
// Two-entry request queue between the front end and the back end.
`default_nettype none
module rvb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rvb_pkg::geom_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output rvb_pkg::geom_t data_o,
  output logic           full_o
);

  rvb_pkg::geom_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/rvb_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with remainder flag.
`default_nettype none
module rvb_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [rvb_pkg::D2_W-1:0]   d2_i,
  input  rvb_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [rvb_pkg::ROOT_W-1:0] root_o,
  output logic                       rem_nz_o,
  output rvb_pkg::side_t             side_o
);

  localparam int RT = rvb_pkg::ROOT_W;

  logic [2*RT-1:0] rad_q  [RT];
  logic [RT+1:0]   rem_q  [RT];
  logic [RT-1:0]   root_q [RT];
  rvb_pkg::side_t  side_q [RT];
  logic [RT-1:0]   vld_q;
  logic [2*RT-1:0] rad0;

  // Radicand is the squared distance scaled by the factor precision
  assign rad0 = (2*RT)'(d2_i) << (2 * rvb_pkg::FACTOR_FRAC_BITS);

  for (genvar k = 0; k < RT; k++) begin : g_stage
    logic [2*RT-1:0] rad_in;
    logic [RT+1:0]   rem_in;
    logic [RT-1:0]   root_in;
    rvb_pkg::side_t  side_in;
    logic            vld_in;
    logic [RT+1:0]   rem_t, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad0;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_t = {rem_in[RT-1:0], rad_in[2*RT-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = (rem_t >= trial);
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? (rem_t - trial) : rem_t;
      root_q[k] <= {root_in[RT-2:0], ge};
      side_q[k] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o  = vld_q[RT-1];
  assign root_o   = root_q[RT-1];
  assign rem_nz_o = (rem_q[RT-1] != '0);
  assign side_o   = side_q[RT-1];

endmodule
`default_nettype wire

// ----- sv/rvb_div.sv -----
// Pipelined restoring divider for the falloff factor, one quotient bit per stage.
`default_nettype none
module rvb_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [rvb_pkg::R_W-1:0] num_i,
  input  logic [rvb_pkg::R_W-1:0] den_i,
  input  rvb_pkg::scl_t           side_i,
  output logic                    valid_o,
  output logic [rvb_pkg::Q_W-1:0] quot_o,
  output rvb_pkg::scl_t           side_o
);

  localparam int RW = rvb_pkg::R_W;
  localparam int QW = rvb_pkg::Q_W;

  logic [RW-1:0] rem_q  [QW];
  logic [RW-1:0] den_q  [QW];
  logic [QW-1:0] quot_q [QW];
  rvb_pkg::scl_t side_q [QW];
  logic [QW-1:0] vld_q;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [RW:0]   t;
    logic [RW-1:0] den_in;
    logic [QW-1:0] quot_in;
    rvb_pkg::scl_t side_in;
    logic          vld_in;
    logic          ge;

    // First stage compares the numerator as is, later ones shift in a zero
    if (j == 0) begin : g_first
      assign t       = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign t       = {rem_q[j-1], 1'b0};
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? RW'(t - {1'b0, den_in}) : RW'(t);
      den_q[j]  <= den_in;
      quot_q[j] <= {quot_in[QW-2:0], ge};
      side_q[j] <= side_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
`default_nettype wire

// ----- sv/radial_vignette_brightness.sv -----
// Top level of the radial vignette brightness block: registers, back end and result stage.
//
// One pixel request is taken per clock while busy is low; busy stays low in
// operation because the back end drains the queue every cycle. Each result
// appears on out_a_o..out_c_o with done_o high for one cycle, in request
// order, after passing through the pipelined square root (one root bit per
// stage) and the pipelined divider (one factor bit per stage). The receiver
// cannot hold results off. Write registers only while no request is in
// flight.
`default_nettype none
module radial_vignette_brightness (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rvb_pkg::COORD_W-1:0]     column_i,
  input  logic [rvb_pkg::COORD_W-1:0]     row_i,
  input  logic [rvb_pkg::CHAN_W-1:0]      chan_a_i,
  input  logic [rvb_pkg::CHAN_W-1:0]      chan_b_i,
  input  logic [rvb_pkg::CHAN_W-1:0]      chan_c_i,
  input  logic                            cfg_we_i,
  input  logic [rvb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rvb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic [rvb_pkg::CHAN_W-1:0]      out_a_o,
  output logic [rvb_pkg::CHAN_W-1:0]      out_b_o,
  output logic [rvb_pkg::CHAN_W-1:0]      out_c_o
);

  localparam int RT = rvb_pkg::ROOT_W;
  localparam int RW = rvb_pkg::R_W;
  localparam int CW = rvb_pkg::CMP_W;
  localparam int SH = rvb_pkg::DIST_SH;
  localparam int FW = rvb_pkg::FRAC_W;
  localparam int NW = FW + rvb_pkg::CHAN_W;

  rvb_pkg::cfg_t   cfg_q;
  rvb_pkg::chans_t ch_in;
  logic            accept;
  logic            fr_valid;
  rvb_pkg::geom_t  fr_item;
  logic            qu_valid, qu_full;
  rvb_pkg::geom_t  qu_item;
  logic            sq_valid, sq_nz;
  logic [RT-1:0]   sq_root;
  rvb_pkg::side_t  sq_side;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= rvb_pkg::CFG_DIM_W'(640);
      cfg_q.height  <= rvb_pkg::CFG_DIM_W'(480);
      cfg_q.start_f <= rvb_pkg::CFG_FAC_W'(4096);
      cfg_q.end_f   <= rvb_pkg::CFG_FAC_W'(6144);
      cfg_q.colour  <= 1'b1;
      cfg_q.enable  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (rvb_pkg::cfg_reg_e'(cfg_idx_i))
        rvb_pkg::REG_IMAGE_WIDTH:       cfg_q.width   <= cfg_data_i[rvb_pkg::CFG_DIM_W-1:0];
        rvb_pkg::REG_IMAGE_HEIGHT:      cfg_q.height  <= cfg_data_i[rvb_pkg::CFG_DIM_W-1:0];
        rvb_pkg::REG_START_FACTOR:      cfg_q.start_f <= cfg_data_i;
        rvb_pkg::REG_END_FACTOR:        cfg_q.end_f   <= cfg_data_i;
        rvb_pkg::REG_PIXEL_FORMAT:      cfg_q.colour  <= cfg_data_i[0];
        rvb_pkg::REG_BRIGHTNESS_ENABLE: cfg_q.enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy   = qu_full;
  assign accept = start && !busy;
  assign ch_in  = '{a: chan_a_i, b: chan_b_i, c: chan_c_i};

  rvb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .column_i (column_i),
    .row_i    (row_i),
    .ch_i     (ch_in),
    .cfg_i    (cfg_q),
    .valid_o  (fr_valid),
    .item_o   (fr_item)
  );

  rvb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_item),
    .pop_i   (1'b1),
    .valid_o (qu_valid),
    .data_o  (qu_item),
    .full_o  (qu_full)
  );

  rvb_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (qu_valid),
    .d2_i     (qu_item.d2),
    .side_i   (qu_item.side),
    .valid_o  (sq_valid),
    .root_o   (sq_root),
    .rem_nz_o (sq_nz),
    .side_o   (sq_side)
  );

  // Classify against the radii and form the divider operands
  logic [CW-1:0]  root_x, rs_x, re_x, dist_x, clamp_x;
  logic           beyond_s, beyond_e;
  rvb_pkg::mode_e mode_d;
  logic [RW-1:0]  num_d, den_d, num_q, den_q;
  rvb_pkg::scl_t  cl_side_q;
  logic           cl_valid_q;

  always_comb begin
    root_x   = CW'(sq_root);
    rs_x     = CW'(sq_side.rs);
    re_x     = CW'(sq_side.re);
    beyond_s = (root_x > rs_x) || ((root_x == rs_x) && sq_nz);
    beyond_e = (root_x > re_x) || ((root_x == re_x) && sq_nz);
    dist_x   = CW'({sq_root[RT-1:SH], SH'(0)});
    if (dist_x < rs_x) begin
      clamp_x = rs_x;
    end else if (dist_x > re_x) begin
      clamp_x = re_x;
    end else begin
      clamp_x = dist_x;
    end
    num_d = RW'(re_x - clamp_x);
    den_d = sq_side.re - sq_side.rs;
    if (!sq_side.enable || !beyond_s) begin
      mode_d = rvb_pkg::MODE_PASS;
    end else if (beyond_e) begin
      mode_d = rvb_pkg::MODE_ZERO;
    end else begin
      mode_d = rvb_pkg::MODE_SCALE;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q            <= num_d;
    den_q            <= den_d;
    cl_side_q.mode   <= mode_d;
    cl_side_q.colour <= sq_side.colour;
    cl_side_q.ch     <= sq_side.ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_valid_q <= 1'b0;
    end else begin
      cl_valid_q <= sq_valid;
    end
  end

  logic                    dv_valid;
  logic [rvb_pkg::Q_W-1:0] dv_quot;
  rvb_pkg::scl_t           dv_side;

  rvb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cl_valid_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (cl_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Saturate the factor, then scale, zero or pass the channels by mode
  logic [FW-1:0]              fac;
  logic [NW-1:0]              pa, pb, pc;
  logic [rvb_pkg::CHAN_W-1:0] oa_d, ob_d, oc_d, oa_q, ob_q, oc_q;
  logic                       done_q;

  always_comb begin
    fac = dv_quot[FW] ? {FW{1'b1}} : dv_quot[FW-1:0];
    pa  = NW'(fac) * NW'(dv_side.ch.a);
    pb  = NW'(fac) * NW'(dv_side.ch.b);
    pc  = NW'(fac) * NW'(dv_side.ch.c);
    oa_d = dv_side.ch.a;
    ob_d = dv_side.ch.b;
    oc_d = dv_side.ch.c;
    case (dv_side.mode)
      rvb_pkg::MODE_ZERO: begin
        oa_d = '0;
        if (dv_side.colour) begin
          ob_d = '0;
          oc_d = '0;
        end
      end
      rvb_pkg::MODE_SCALE: begin
        oa_d = pa[NW-1:FW];
        if (dv_side.colour) begin
          ob_d = pb[NW-1:FW];
          oc_d = pc[NW-1:FW];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    oa_q <= oa_d;
    ob_q <= ob_d;
    oc_q <= oc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  assign done_o  = done_q;
  assign out_a_o = oa_q;
  assign out_b_o = ob_q;
  assign out_c_o = oc_q;

endmodule
`default_nettype wire

// ----- sv/rvb_checker.sv -----
// Port-level checks for the radial vignette brightness block, bound to the top level.
`default_nettype none
module rvb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [rvb_pkg::CHAN_W-1:0] chan_a_i,
  input logic [rvb_pkg::CHAN_W-1:0] chan_b_i,
  input logic                       done_o,
  input logic [rvb_pkg::CHAN_W-1:0] out_a_o,
  input logic [rvb_pkg::CHAN_W-1:0] out_b_o
);

  localparam int LAT = rvb_pkg::LATENCY;
  localparam int WW  = $clog2(LAT + 1);

  logic [WW-1:0] warm_q;
  logic          warm;

  // Cycles since reset, so history checks skip the reset window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != WW'(LAT)) begin
      warm_q <= warm_q + WW'(1);
    end
  end
  assign warm = (warm_q == WW'(LAT));

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the back end never stalls");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_request_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start && !busy, LAT)) |-> done_o)
    else $error("request lost in the pipeline");

  a_never_brighter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && done_o) |-> ((out_a_o <= $past(chan_a_i, LAT)) &&
                          (out_b_o <= $past(chan_b_i, LAT))))
    else $error("output channel brighter than its input");

endmodule

bind radial_vignette_brightness rvb_checker u_rvb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .chan_a_i (chan_a_i),
  .chan_b_i (chan_b_i),
  .done_o   (done_o),
  .out_a_o  (out_a_o),
  .out_b_o  (out_b_o)
);
`default_nettype wire

// ----- bench/rvb_checker.sv -----
// Checker for the radial vignette block: predicts each pixel and compares results.
`timescale 1ns / 100ps
module rvb_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic [rvb_pkg::COORD_W-1:0]    column_i,
  input  logic [rvb_pkg::COORD_W-1:0]    row_i,
  input  logic [rvb_pkg::CHAN_W-1:0]     chan_a_i,
  input  logic [rvb_pkg::CHAN_W-1:0]     chan_b_i,
  input  logic [rvb_pkg::CHAN_W-1:0]     chan_c_i,
  input  logic                           cfg_we_i,
  input  logic [rvb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rvb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           done_o,
  input  logic [rvb_pkg::CHAN_W-1:0]     out_a_o,
  input  logic [rvb_pkg::CHAN_W-1:0]     out_b_o,
  input  logic [rvb_pkg::CHAN_W-1:0]     out_c_o,
  output int                             fail_count,
  output int                             pending
);
  import rvb_pkg::*;

  logic [12:0] img_w, img_h;
  logic [15:0] start_f, end_f;
  logic        colour, enable;
  chans_t      expected_pixels[$];

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic chans_t vignette(logic [11:0] col, logic [11:0] row, chans_t px);
    longint unsigned w1, h1, sf, ef, d2, rs, re, dsc, dist_fx, den, num, f;
    longint signed dx, dy;
    chans_t r;
    r = px;
    w1 = (img_w == 0) ? 0 : ((img_w > MAX_DIM) ? MAX_DIM - 1 : img_w - 1);
    h1 = (img_h == 0) ? 0 : ((img_h > MAX_DIM) ? MAX_DIM - 1 : img_h - 1);
    sf = start_f;
    ef = (end_f < start_f) ? start_f : end_f;
    dx = 2 * longint'(col) - longint'(w1);
    dy = 2 * longint'(row) - longint'(h1);
    d2 = dx * dx + dy * dy;
    rs = w1 * sf;
    re = w1 * ef;
    dsc = d2 << (2 * FACTOR_FRAC_BITS);
    if (enable && dsc > rs * rs) begin
      if (dsc > re * re) begin
        r.a = 0;
        if (colour) begin
          r.b = 0;
          r.c = 0;
        end
      end else begin
        dist_fx = int_sqrt(d2 << 14) << (FACTOR_FRAC_BITS - 7);
        den = re - rs;
        num = (dist_fx > rs) ? dist_fx - rs : 0;
        if (num > den) num = den;
        f = ((den - num) << 16) / den;
        if (f > 16'hFFFF) f = 16'hFFFF;
        r.a = 8'((f * px.a) >> 16);
        if (colour) begin
          r.b = 8'((f * px.b) >> 16);
          r.c = 8'((f * px.c) >> 16);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_pixels.size();

  initial fail_count = 0;

  // Register shadow, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    chans_t want;
    if (!rst_ni) begin
      img_w <= 640;
      img_h <= 480;
      start_f <= 4096;
      end_f <= 6144;
      colour <= 1;
      enable <= 1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH: img_w <= cfg_data_i[12:0];
          REG_IMAGE_HEIGHT: img_h <= cfg_data_i[12:0];
          REG_START_FACTOR: start_f <= cfg_data_i;
          REG_END_FACTOR: end_f <= cfg_data_i;
          REG_PIXEL_FORMAT: colour <= cfg_data_i[0];
          REG_BRIGHTNESS_ENABLE: enable <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_pixels.push_back(vignette(column_i, row_i, '{chan_a_i, chan_b_i, chan_c_i}));
      if (done_o) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_a_o !== want.a) report_mismatch("out_a", out_a_o, want.a);
          if (out_b_o !== want.b) report_mismatch("out_b", out_b_o, want.b);
          if (out_c_o !== want.c) report_mismatch("out_c", out_c_o, want.c);
        end
      end
    end
  end
endmodule

// ----- bench/tb_radial_vignette_brightness.sv -----
// Testbench top for the radial vignette block: stimulus, settings sweep and verdict.
`timescale 1ns / 100ps
module tb_radial_vignette_brightness;
  import rvb_pkg::*;

  localparam int WATCHDOG = 5000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [11:0] column_i = 0, row_i = 0;
  logic [7:0]  chan_a_i = 0, chan_b_i = 0, chan_c_i = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [15:0] cfg_data_i = 0;
  logic        done_o;
  logic [7:0]  out_a_o, out_b_o, out_c_o;
  int          fail_count, pending, idle_cycles;
  bit          allow_idle;
  logic [12:0] cur_w, cur_h;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  radial_vignette_brightness DUT (.*);
  rvb_scoreboard u_checker (.*);

  // Watchdog on cycles without any request or result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_IMAGE_WIDTH) cur_w = data[12:0];
    if (idx == REG_IMAGE_HEIGHT) cur_h = data[12:0];
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // One pixel request; random gap first when idling is allowed
  task automatic send_pixel(logic [11:0] col, logic [11:0] row,
                            logic [7:0] a, logic [7:0] b, logic [7:0] c);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    start <= 1;
    column_i <= col;
    row_i <= row;
    chan_a_i <= a;
    chan_b_i <= b;
    chan_c_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    start <= 0;
  endtask

  // Random pixel, mostly within the image, sometimes anywhere
  task automatic random_pixel();
    logic [11:0] col, row;
    if ($urandom_range(0, 7) == 0) begin
      col = $urandom;
      row = $urandom;
    end else begin
      col = $urandom_range(0, (cur_w > 1 ? cur_w : 1) - 1);
      row = $urandom_range(0, (cur_h > 1 ? cur_h : 1) - 1);
    end
    send_pixel(col, row, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int unsigned sf;
    cur_w = 640;
    cur_h = 480;
    allow_idle = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: reset settings, corners, centre, extremes
    send_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(319, 239, 8'hFF, 8'h80, 8'h01);
    send_pixel(639, 479, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'hFFF, 12'hFFF, 8'hAA, 8'h55, 8'hFF);
    send_pixel(500, 240, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(560, 300, 8'h7F, 8'hFF, 8'h00);
    send_pixel(600, 240, 8'hFF, 8'hFF, 8'hFF);
    stop_requests();
    drain();
    // Grayscale, end below start
    write_reg(REG_PIXEL_FORMAT, 0);
    write_reg(REG_END_FACTOR, 2048);
    send_pixel(560, 240, 8'hFF, 8'h12, 8'h34);
    send_pixel(0, 0, 8'hFF, 8'h12, 8'h34);
    send_pixel(639, 0, 8'hC0, 8'hFF, 8'hFF);
    stop_requests();
    drain();
    // Disabled, zero and oversize dimensions, zero and full-scale factors
    write_reg(REG_BRIGHTNESS_ENABLE, 0);
    send_pixel(0, 0, 8'hFF, 8'hEE, 8'hDD);
    stop_requests();
    drain();
    write_reg(REG_BRIGHTNESS_ENABLE, 1);
    write_reg(REG_PIXEL_FORMAT, 1);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 16'h1FFF);
    write_reg(REG_START_FACTOR, 0);
    write_reg(REG_END_FACTOR, 16'hFFFF);
    send_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(0, 2047, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
    stop_requests();
    drain();
    write_reg(REG_IMAGE_WIDTH, 4096);
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_START_FACTOR, 16'hFFFF);
    send_pixel(12'hFFF, 0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(2048, 0, 8'hFF, 8'hFF, 8'hFF);
    stop_requests();
    drain();

    // Random phases over random settings
    for (int ph = 0; ph < 25; ph++) begin
      write_reg(REG_IMAGE_WIDTH, (ph % 6 == 0) ? 16'($urandom) : $urandom_range(1, 4096));
      write_reg(REG_IMAGE_HEIGHT, (ph % 6 == 1) ? 16'($urandom) : $urandom_range(1, 4096));
      sf = $urandom_range(0, 8192);
      write_reg(REG_START_FACTOR, (ph % 5 == 0) ? 16'($urandom) : 16'(sf));
      write_reg(REG_END_FACTOR, (ph % 7 == 0) ? 16'(sf) :
                (ph % 4 == 0) ? 16'($urandom) : 16'(sf + $urandom_range(1, 8192)));
      write_reg(REG_PIXEL_FORMAT, (ph % 3 != 0));
      write_reg(REG_BRIGHTNESS_ENABLE, (ph % 8 != 3));
      allow_idle = (ph < 21);
      repeat (50) random_pixel();
      stop_requests();
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/rvb_pkg.sv
sv/rvb_front.sv
sv/rvb_queue.sv
sv/rvb_isqrt.sv
sv/rvb_div.sv
sv/radial_vignette_brightness.sv
sv/rvb_checker.sv
bench/rvb_checker.sv
bench/tb_radial_vignette_brightness.sv
